// ----- hw/rtl/qlik_pkg.sv -----
package qlik_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int LEN_W          = 15;
  localparam int CORDIC_STEPS   = 32;
  localparam int FRONT_LAT      = 6;
  localparam int SQ_LAT         = 2 + 32;
  localparam int AT_LAT         = 1 + 6 + CORDIC_STEPS + 1;
  localparam longint unsigned TURN_PER_RAD_Q32 = 64'd683565276;

  typedef enum logic [2:0] {
    REG_MOUNT_X      = 3'd0,
    REG_MOUNT_Y      = 3'd1,
    REG_MOUNT_Z      = 3'd2,
    REG_HIP_LENGTH   = 3'd3,
    REG_UPPER_LENGTH = 3'd4,
    REG_LOWER_LENGTH = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic fail;
  } front_ctl_t;

  // atan(2^-i) in Q32 turns: power series in Q62 radians, truncating terms
  function automatic logic [31:0] step_angle(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] prod;
    int n;
    int e;
    if (i == 0) begin
      return 32'h2000_0000;
    end
    acc = '0;
    n = 0;
    e = 62 - i;
    while (e >= 0) begin
      term = (64'd1 << e) / 64'(2 * n + 1);
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
      n = n + 1;
      e = 62 - i * (2 * n + 1);
    end
    prod = (acc >> 30) * TURN_PER_RAD_Q32 + (64'd1 << 31);
    return prod[63:32];
  endfunction

endpackage

// ----- hw/rtl/qlik_front.sv -----
module qlik_front #(
  parameter int COORD_BITS = qlik_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [COORD_BITS-1:0]         body_x,
  input  logic signed [COORD_BITS-1:0]         body_y,
  input  logic signed [COORD_BITS-1:0]         body_z,
  input  logic signed [COORD_BITS-1:0]         foot_x,
  input  logic signed [COORD_BITS-1:0]         foot_y,
  input  logic signed [COORD_BITS-1:0]         foot_z,
  input  logic signed [COORD_BITS-1:0]         mount_x,
  input  logic signed [COORD_BITS-1:0]         mount_y,
  input  logic signed [COORD_BITS-1:0]         mount_z,
  input  logic        [qlik_pkg::LEN_W-1:0]    hip_length,
  input  logic        [qlik_pkg::LEN_W-1:0]    upper_length,
  input  logic        [qlik_pkg::LEN_W-1:0]    lower_length,
  output qlik_pkg::front_ctl_t                 ctl,
  output logic signed [COORD_BITS+1:0]         lx,
  output logic signed [COORD_BITS+1:0]         ly,
  output logic signed [COORD_BITS+1:0]         lz,
  output logic        [63:0]                   qa,
  output logic        [63:0]                   qb,
  output logic        [63:0]                   qc,
  output logic signed [63:0]                   pc
);

  localparam int LW  = COORD_BITS + 2;
  localparam int SQ  = 2 * LW;
  localparam int DW  = (2 * LW + 2 > 34) ? 2 * LW + 2 : 34;
  localparam int LSQ = 2 * qlik_pkg::LEN_W;
  localparam int NST = qlik_pkg::FRONT_LAT;

  logic [NST-1:0] v;

  logic signed [LW-1:0] lx_p [NST];
  logic signed [LW-1:0] ly_p [NST];
  logic signed [LW-1:0] lz_p [NST];

  logic signed [SQ-1:0]  lxe, lye, lze;
  logic        [LSQ-1:0] l1e, l2e, l3e;

  logic signed [SQ-1:0]  s2_lx2, s2_ly2, s2_lz2;
  logic        [LSQ-1:0] s2_l1sq, s2_l2sq, s2_l3sq, s2_l23;

  logic signed [DW-1:0]  s3_d;
  logic        [LSQ:0]   s3_e2, s3_den;
  logic signed [SQ-1:0]  s3_ly2;

  logic signed [DW-1:0]  s4_c, s4_qb, s4_d;
  logic                  s4_f1;
  logic        [LSQ:0]   s4_den;

  logic signed [DW-1:0]  dene, diff, summ;
  logic                  s5_fail;
  logic        [31:0]    s5_um, s5_up;
  logic signed [DW-1:0]  s5_c, s5_qb, s5_d;

  logic                  out_fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[NST-2:0], in_valid};
    end
  end

  always_comb begin
    lxe  = SQ'(lx_p[0]);
    lye  = SQ'(ly_p[0]);
    lze  = SQ'(lz_p[0]);
    l1e  = LSQ'(hip_length);
    l2e  = LSQ'(upper_length);
    l3e  = LSQ'(lower_length);
    dene = DW'(s4_den);
    diff = dene - s4_c;
    summ = dene + s4_c;
  end

  always_ff @(posedge clk) begin
    // leg vector
    lx_p[0] <= LW'(mount_x) + LW'(body_x) - LW'(foot_x);
    ly_p[0] <= LW'(mount_y) + LW'(body_y) - LW'(foot_y);
    lz_p[0] <= LW'(mount_z) + LW'(body_z) - LW'(foot_z);
    for (int m = 1; m < NST; m++) begin
      lx_p[m] <= lx_p[m-1];
      ly_p[m] <= ly_p[m-1];
      lz_p[m] <= lz_p[m-1];
    end

    // squares
    s2_lx2  <= lxe * lxe;
    s2_ly2  <= lye * lye;
    s2_lz2  <= lze * lze;
    s2_l1sq <= l1e * l1e;
    s2_l2sq <= l2e * l2e;
    s2_l3sq <= l3e * l3e;
    s2_l23  <= l2e * l3e;

    s3_d   <= DW'(s2_lx2) + DW'(s2_lz2) - DW'(s2_l1sq);
    s3_e2  <= (LSQ+1)'(s2_l2sq) + (LSQ+1)'(s2_l3sq);
    s3_den <= {s2_l23, 1'b0};
    s3_ly2 <= s2_ly2;

    s4_c   <= s3_d - DW'(s3_e2);
    s4_qb  <= s3_d - DW'(s3_ly2);
    s4_f1  <= (s3_d <= 0) || (DW'(s3_ly2) > s3_d);
    s4_d   <= s3_d;
    s4_den <= s3_den;

    s5_fail <= s4_f1 || (s4_den == '0) || (s4_c > dene) || (s4_c < -dene);
    s5_um   <= diff[31:0];
    s5_up   <= summ[31:0];
    s5_c    <= s4_c;
    s5_qb   <= s4_qb;
    s5_d    <= s4_d;

    // gamma radicand (den - c)(den + c), below 2^62 when in reach
    qc       <= {32'd0, s5_um} * {32'd0, s5_up};
    qa       <= 64'(s5_d);
    qb       <= 64'(s5_qb);
    pc       <= 64'(s5_c);
    out_fail <= s5_fail;
  end

  assign ctl = '{valid: v[NST-1], fail: out_fail};
  assign lx = lx_p[NST-1];
  assign ly = ly_p[NST-1];
  assign lz = lz_p[NST-1];

endmodule

// ----- hw/rtl/qlik_sqrt.sv -----
module qlik_sqrt (
  input  logic               clk,
  input  logic        [63:0] q,
  input  logic signed [63:0] p,
  output logic        [31:0] s,
  output logic signed [63:0] ps
);

  localparam int STEPS = 32;

  logic        [63:0] ap;
  logic        [15:0] fit;
  logic        [4:0]  k_next;
  logic        [4:0]  k_a;
  logic        [63:0] q_a;
  logic signed [63:0] p_a;

  logic        [63:0] n_r [STEPS];
  logic        [63:0] r_r [STEPS+1];
  logic signed [63:0] p_r [STEPS+1];

  // scale exponent: thresholds fall with k, so the count of fits is the first miss
  always_comb begin
    ap = p[63] ? -p : p;
    k_next = '0;
    for (int j = 0; j < 16; j++) begin
      fit[j] = (q < (64'd1 << (60 - 2 * j))) && (ap < (64'd1 << (61 - j)));
      k_next = k_next + 5'(fit[j]);
    end
  end

  always_ff @(posedge clk) begin
    k_a    <= k_next;
    q_a    <= q;
    p_a    <= p;
    n_r[0] <= q_a << {k_a, 1'b0};
    r_r[0] <= '0;
    p_r[0] <= p_a <<< k_a;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    logic        take;

    assign trial = r_r[i] + BIT;
    assign take  = (n_r[i] >= trial);

    always_ff @(posedge clk) begin
      r_r[i+1] <= take ? (r_r[i] >> 1) + BIT : r_r[i] >> 1;
      p_r[i+1] <= p_r[i];
    end

    if (i < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        n_r[i+1] <= take ? n_r[i] - trial : n_r[i];
      end
    end
  end

  assign s  = r_r[STEPS][31:0];
  assign ps = p_r[STEPS];

endmodule

// ----- hw/rtl/qlik_atan2.sv -----
module qlik_atan2 (
  input  logic               clk,
  input  logic signed [63:0] y,
  input  logic signed [63:0] x,
  output logic        [31:0] t
);

  localparam int NORM  = 6;
  localparam int STEPS = qlik_pkg::CORDIC_STEPS;
  localparam int FD    = 1 + NORM + STEPS;
  localparam int CW    = 34;

  typedef struct packed {
    logic yz;
    logic xz;
    logic xneg;
    logic yneg;
  } at_flags_t;

  at_flags_t fl [FD];

  logic [63:0] ax_n [NORM+1];
  logic [63:0] ay_n [NORM+1];

  logic signed [CW-1:0] cx_r [STEPS-1];
  logic signed [CW-1:0] cy_r [STEPS-1];
  logic        [31:0]   t_r  [STEPS];

  logic [31:0] tsel;

  always_ff @(posedge clk) begin
    ax_n[0] <= x[63] ? -x : x;
    ay_n[0] <= y[63] ? -y : y;
    fl[0]   <= '{yz: (y == '0), xz: (x == '0), xneg: x[63], yneg: y[63]};
    for (int m = 1; m < FD; m++) begin
      fl[m] <= fl[m-1];
    end
  end

  // left-normalise so the leading one of the larger magnitude sits at bit 63
  for (genvar j = 0; j < NORM; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic [63:0] w;
    assign w = ax_n[j] | ay_n[j];
    always_ff @(posedge clk) begin
      if (w[63 -: SH] == '0) begin
        ax_n[j+1] <= ax_n[j] << SH;
        ay_n[j+1] <= ay_n[j] << SH;
      end else begin
        ax_n[j+1] <= ax_n[j];
        ay_n[j+1] <= ay_n[j];
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    localparam logic [31:0] ANG = qlik_pkg::step_angle(i);
    logic signed [CW-1:0] cx_in, cy_in, sx, sy;
    logic        [31:0]   t_in;

    if (i == 0) begin : g_first
      // top 30 bits: larger magnitude lands in [2^29, 2^30)
      assign cx_in = CW'(ax_n[NORM][63:34]);
      assign cy_in = CW'(ay_n[NORM][63:34]);
      assign t_in  = '0;
    end else begin : g_next
      assign cx_in = cx_r[i-1];
      assign cy_in = cy_r[i-1];
      assign t_in  = t_r[i-1];
    end

    assign sx = cx_in >>> i;
    assign sy = cy_in >>> i;

    always_ff @(posedge clk) begin
      t_r[i] <= cy_in[CW-1] ? t_in - ANG : t_in + ANG;
    end

    if (i < STEPS - 1) begin : g_vec
      always_ff @(posedge clk) begin
        if (!cy_in[CW-1]) begin
          cx_r[i] <= cx_in + sy;
          cy_r[i] <= cy_in - sx;
        end else begin
          cx_r[i] <= cx_in - sy;
          cy_r[i] <= cy_in + sx;
        end
      end
    end
  end

  always_comb begin
    if (fl[FD-1].yz) tsel = '0;
    else if (fl[FD-1].xz) tsel = 32'h4000_0000;
    else tsel = t_r[STEPS-1];
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    if (!fl[FD-1].xneg) begin
      t <= fl[FD-1].yneg ? -tsel : tsel;
    end else begin
      t <= fl[FD-1].yneg ? 32'h8000_0000 + tsel : 32'h8000_0000 - tsel;
    end
  end

endmodule

// ----- hw/rtl/quadruped_leg_inverse_kinematics.sv -----
// Channel   Ports                                          Timing
// item in   start, busy, body_x/y/z, foot_x/y/z            taken when start && !busy
// result    done, hip/shoulder/knee_angle, unreachable     one cycle, done high
// config    cfg_write, cfg_index, cfg_data                 written when cfg_write
//
// One item can enter every cycle while busy is low; each result passes through
// 6 front-end stages, 34 for the square roots, 40 for the CORDIC units, 1 out.
// The depth is set by the 32-step root and 32-step CORDIC pipelines.
// rst is synchronous; busy is high during reset and low otherwise.
// The receiver cannot stall, so items flow straight through.
module quadruped_leg_inverse_kinematics #(
  parameter int ANGLE_BITS = qlik_pkg::ANGLE_BITS_DEF,
  parameter int COORD_BITS = qlik_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [((COORD_BITS > qlik_pkg::LEN_W) ? COORD_BITS : qlik_pkg::LEN_W)-1:0] cfg_data,
  input  logic signed [COORD_BITS-1:0]  body_x,
  input  logic signed [COORD_BITS-1:0]  body_y,
  input  logic signed [COORD_BITS-1:0]  body_z,
  input  logic signed [COORD_BITS-1:0]  foot_x,
  input  logic signed [COORD_BITS-1:0]  foot_y,
  input  logic signed [COORD_BITS-1:0]  foot_z,
  output logic                          done,
  output logic [ANGLE_BITS-1:0]         hip_angle,
  output logic [ANGLE_BITS-1:0]         shoulder_angle,
  output logic [ANGLE_BITS-1:0]         knee_angle,
  output logic                          unreachable
);

  localparam int LW   = COORD_BITS + 2;
  localparam int SQD  = qlik_pkg::SQ_LAT;
  localparam int CD   = qlik_pkg::SQ_LAT + qlik_pkg::AT_LAT;
  localparam int LAT  = qlik_pkg::FRONT_LAT + CD + 1;
  localparam logic [31:0] RND = 32'd1 << (31 - ANGLE_BITS);

  logic signed [COORD_BITS-1:0]      mount_x, mount_y, mount_z;
  logic        [qlik_pkg::LEN_W-1:0] hip_length, upper_length, lower_length;

  qlik_pkg::front_ctl_t f_ctl;
  qlik_pkg::front_ctl_t ctl_dl [CD];

  logic signed [LW-1:0] f_lx, f_ly, f_lz;
  logic        [63:0]   f_qa, f_qb, f_qc;
  logic signed [63:0]   f_pc;

  logic signed [LW-1:0] lx_dl [SQD];
  logic signed [LW-1:0] lz_dl [SQD];

  logic        [31:0] s_a, s_b, s_c;
  logic signed [63:0] ps_a, ps_b, ps_c;
  logic        [31:0] t0, t1, t2, t3;
  logic        [31:0] ra, rb, rc;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_x      <= '0;
      mount_y      <= '0;
      mount_z      <= '0;
      hip_length   <= '0;
      upper_length <= qlik_pkg::LEN_W'(1);
      lower_length <= qlik_pkg::LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        qlik_pkg::REG_MOUNT_X:      mount_x      <= cfg_data[COORD_BITS-1:0];
        qlik_pkg::REG_MOUNT_Y:      mount_y      <= cfg_data[COORD_BITS-1:0];
        qlik_pkg::REG_MOUNT_Z:      mount_z      <= cfg_data[COORD_BITS-1:0];
        qlik_pkg::REG_HIP_LENGTH:   hip_length   <= cfg_data[qlik_pkg::LEN_W-1:0];
        qlik_pkg::REG_UPPER_LENGTH: upper_length <= cfg_data[qlik_pkg::LEN_W-1:0];
        qlik_pkg::REG_LOWER_LENGTH: lower_length <= cfg_data[qlik_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  qlik_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .body_x       (body_x),
    .body_y       (body_y),
    .body_z       (body_z),
    .foot_x       (foot_x),
    .foot_y       (foot_y),
    .foot_z       (foot_z),
    .mount_x      (mount_x),
    .mount_y      (mount_y),
    .mount_z      (mount_z),
    .hip_length   (hip_length),
    .upper_length (upper_length),
    .lower_length (lower_length),
    .ctl          (f_ctl),
    .lx           (f_lx),
    .ly           (f_ly),
    .lz           (f_lz),
    .qa           (f_qa),
    .qb           (f_qb),
    .qc           (f_qc),
    .pc           (f_pc)
  );

  qlik_sqrt u_sqrt_a (.clk(clk), .q(f_qa), .p(64'(hip_length)), .s(s_a), .ps(ps_a));
  qlik_sqrt u_sqrt_b (.clk(clk), .q(f_qb), .p(64'(f_ly)),       .s(s_b), .ps(ps_b));
  qlik_sqrt u_sqrt_c (.clk(clk), .q(f_qc), .p(f_pc),            .s(s_c), .ps(ps_c));

  always_ff @(posedge clk) begin
    lx_dl[0] <= f_lx;
    lz_dl[0] <= f_lz;
    for (int m = 1; m < SQD; m++) begin
      lx_dl[m] <= lx_dl[m-1];
      lz_dl[m] <= lz_dl[m-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < CD; m++) begin
        ctl_dl[m] <= '0;
      end
    end else begin
      ctl_dl[0] <= f_ctl;
      for (int m = 1; m < CD; m++) begin
        ctl_dl[m] <= ctl_dl[m-1];
      end
    end
  end

  qlik_atan2 u_at0 (.clk(clk), .y(64'(lx_dl[SQD-1])), .x(64'(lz_dl[SQD-1])), .t(t0));
  qlik_atan2 u_at1 (.clk(clk), .y({32'd0, s_a}),      .x(ps_a),              .t(t1));
  qlik_atan2 u_at2 (.clk(clk), .y(ps_b),              .x({32'd0, s_b}),      .t(t2));
  qlik_atan2 u_at3 (.clk(clk), .y({32'd0, s_c}),      .x(ps_c),              .t(t3));

  // angles in Q32 turns, wrapping
  always_comb begin
    ra = 32'h8000_0000 - t0 - t1 + RND;
    rb = t2 + 32'h4000_0000 + RND;
    rc = t3 + RND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_dl[CD-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    unreachable    <= ctl_dl[CD-1].fail;
    hip_angle      <= ctl_dl[CD-1].fail ? '0 : ra[31 -: ANGLE_BITS];
    shoulder_angle <= ctl_dl[CD-1].fail ? '0 : rb[31 -: ANGLE_BITS];
    knee_angle     <= ctl_dl[CD-1].fail ? '0 : rc[31 -: ANGLE_BITS];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LAT) done)
    else $error("item accepted without a result after the pipeline latency");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (done && unreachable) |->
      (hip_angle == '0 && shoulder_angle == '0 && knee_angle == '0))
    else $error("unreachable result carries non-zero angles");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe straight after reset");

endmodule

// ----- sim/leg_ik_checker.sv -----
module leg_ik_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic signed [15:0] body_x,
  input  logic signed [15:0] body_y,
  input  logic signed [15:0] body_z,
  input  logic signed [15:0] foot_x,
  input  logic signed [15:0] foot_y,
  input  logic signed [15:0] foot_z,
  input  logic               done,
  input  logic [15:0]        hip_angle,
  input  logic [15:0]        shoulder_angle,
  input  logic [15:0]        knee_angle,
  input  logic               unreachable,
  output int                 fail_count,
  output int                 angles_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] hip;
    logic [15:0] shoulder;
    logic [15:0] knee;
    logic        out_of_reach;
  } joint_set_t;

  joint_set_t  expected_angles[$];
  logic [31:0] arc_step[32];
  longint      mnt_x, mnt_y, mnt_z, len_hip, len_upper, len_lower;

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // angle of (x, y) in Q32 turns
  function automatic logic [31:0] vec_angle(longint y, longint x);
    longint unsigned ax, ay, m;
    longint          cx, cy, sx, sy;
    logic [31:0]     t;
    ax = absval(x);
    ay = absval(y);
    if (ax == 0 && ay == 0) return 32'd0;
    if (ay == 0) begin
      t = 32'd0;
    end else if (ax == 0) begin
      t = 32'h4000_0000;
    end else begin
      m = ax > ay ? ax : ay;
      while (m >= (64'd1 << 30)) begin
        m = m >> 1; ax = ax >> 1; ay = ay >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1; ax = ax << 1; ay = ay << 1;
      end
      cx = ax;
      cy = ay;
      t = 32'd0;
      for (int i = 0; i < 32; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (cy >= 0) begin
          cx = cx + sy; cy = cy - sx; t = t + arc_step[i];
        end else begin
          cx = cx - sy; cy = cy + sx; t = t - arc_step[i];
        end
      end
    end
    if (x >= 0) return y >= 0 ? t : 32'd0 - t;
    return y >= 0 ? 32'h8000_0000 - t : 32'h8000_0000 + t;
  endfunction

  function automatic longint unsigned root_scaled(longint unsigned q, longint p,
                                                  output longint p_scaled);
    int k;
    k = 0;
    while (k < 16 && q < (64'd1 << (60 - 2 * k)) && absval(p) < (64'd1 << (61 - k)))
      k++;
    p_scaled = p * (longint'(1) << k);
    return int_root(q << (2 * k));
  endfunction

  function automatic logic [15:0] round_angle(logic [31:0] v);
    logic [31:0] r;
    r = v + 32'h0000_8000;
    return r[31:16];
  endfunction

  function automatic joint_set_t solve_leg(longint bx, longint by, longint bz,
                                           longint fx, longint fy, longint fz);
    joint_set_t      js;
    longint          lx, ly, lz, d, den, c, ps;
    longint unsigned s;
    logic [31:0]     al, be, ga;
    lx = mnt_x + bx - fx;
    ly = mnt_y + by - fy;
    lz = mnt_z + bz - fz;
    d = lx * lx + lz * lz - len_hip * len_hip;
    den = 2 * len_upper * len_lower;
    c = d - len_upper * len_upper - len_lower * len_lower;
    js = '{16'd0, 16'd0, 16'd0, 1'b1};
    if (d <= 0 || ly * ly > d || den == 0 || c > den || c < -den) return js;
    s = root_scaled(d, len_hip, ps);
    al = 32'h8000_0000 - vec_angle(lx, lz) - vec_angle(longint'(s), ps);
    s = root_scaled(d - ly * ly, ly, ps);
    be = vec_angle(ps, longint'(s)) + 32'h4000_0000;
    s = root_scaled((den - c) * (den + c), c, ps);
    ga = vec_angle(longint'(s), ps);
    js = '{round_angle(al), round_angle(be), round_angle(ga), 1'b0};
    return js;
  endfunction

  initial begin
    longint unsigned acc, term;
    int n, e;
    fail_count = 0;
    arc_step[0] = 32'h2000_0000;
    for (int i = 1; i < 32; i++) begin
      acc = 0;
      n = 0;
      e = 62 - i;
      while (e >= 0) begin
        term = (64'd1 << e) / longint'(2 * n + 1);
        acc = (n % 2) ? acc - term : acc + term;
        n++;
        e = 62 - i * (2 * n + 1);
      end
      acc = (acc >> 30) * qlik_pkg::TURN_PER_RAD_Q32 + (64'd1 << 31);
      arc_step[i] = acc[63:32];
    end
  end

  always @(posedge clk) begin
    joint_set_t want;
    if (rst) begin
      mnt_x <= 0; mnt_y <= 0; mnt_z <= 0;
      len_hip <= 0; len_upper <= 1; len_lower <= 1;
    end else begin
      if (cfg_write) begin
        case (qlik_pkg::cfg_reg_t'(cfg_index))
          qlik_pkg::REG_MOUNT_X:      mnt_x <= longint'($signed(cfg_data));
          qlik_pkg::REG_MOUNT_Y:      mnt_y <= longint'($signed(cfg_data));
          qlik_pkg::REG_MOUNT_Z:      mnt_z <= longint'($signed(cfg_data));
          qlik_pkg::REG_HIP_LENGTH:   len_hip <= longint'(cfg_data[14:0]);
          qlik_pkg::REG_UPPER_LENGTH: len_upper <= longint'(cfg_data[14:0]);
          qlik_pkg::REG_LOWER_LENGTH: len_lower <= longint'(cfg_data[14:0]);
          default: ;
        endcase
      end
      if (start && !busy)
        expected_angles.push_back(solve_leg(body_x, body_y, body_z, foot_x, foot_y, foot_z));
      if (done) begin
        if (expected_angles.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = expected_angles.pop_front();
          if (hip_angle !== want.hip) begin
            $error("hip_angle: expected %0d, got %0d", want.hip, hip_angle);
            fail_count++;
          end
          if (shoulder_angle !== want.shoulder) begin
            $error("shoulder_angle: expected %0d, got %0d", want.shoulder, shoulder_angle);
            fail_count++;
          end
          if (knee_angle !== want.knee) begin
            $error("knee_angle: expected %0d, got %0d", want.knee, knee_angle);
            fail_count++;
          end
          if (unreachable !== want.out_of_reach) begin
            $error("unreachable: expected %0d, got %0d", want.out_of_reach, unreachable);
            fail_count++;
          end
        end
      end
    end
    angles_pending <= expected_angles.size();
  end
endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk, rst, start, busy, cfg_write, done, unreachable;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic signed [15:0] body_x, body_y, body_z, foot_x, foot_y, foot_z;
  logic [15:0]        hip_angle, shoulder_angle, knee_angle;
  int                 fail_count, angles_pending;
  int                 sender_idle;
  int                 mx, my, mz, reach;

  quadruped_leg_inverse_kinematics dut (.*);
  leg_ik_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

  // one write, then cfg_write drops before the next so back-to-back writes never overlap
  task automatic set_reg(qlik_pkg::cfg_reg_t idx, int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // idle pause: all items out and pipeline drained
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (angles_pending != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic set_leg(int x, int y, int z, int hip, int up, int lo);
    set_reg(qlik_pkg::REG_MOUNT_X, x);
    set_reg(qlik_pkg::REG_MOUNT_Y, y);
    set_reg(qlik_pkg::REG_MOUNT_Z, z);
    set_reg(qlik_pkg::REG_HIP_LENGTH, hip);
    set_reg(qlik_pkg::REG_UPPER_LENGTH, up);
    set_reg(qlik_pkg::REG_LOWER_LENGTH, lo);
    @(posedge clk);
  endtask

  task automatic put_item(int bx, int by, int bz, int fx, int fy, int fz);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    body_x <= bx[15:0]; body_y <= by[15:0]; body_z <= bz[15:0];
    foot_x <= fx[15:0]; foot_y <= fy[15:0]; foot_z <= fz[15:0];
    do @(posedge clk); while (busy);
  endtask

  function automatic int srand(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // mostly legs with each offset bounded by the current reach, some raw noise
  task automatic random_items(int count);
    int lx, ly, lz, bx, by, bz;
    repeat (count) begin
      if ($urandom_range(99) < 20) begin
        put_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        lx = srand(reach); ly = srand(reach / 2); lz = srand(reach);
        bx = srand(8000); by = srand(8000); bz = srand(8000);
        put_item(bx, by, bz, mx + bx - lx, my + by - ly, mz + bz - lz);
      end
    end
  endtask

  task automatic random_phase(int count);
    int hip, up, lo;
    mx = srand(8000); my = srand(8000); mz = srand(8000);
    hip = $urandom_range(0, 3000);
    up = $urandom_range(1500, 6000);
    lo = $urandom_range(1500, 6000);
    reach = hip + up + lo;
    set_leg(mx, my, mz, hip, up, lo);
    random_items(count);
    drain();
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    body_x = '0; body_y = '0; body_z = '0; foot_x = '0; foot_y = '0; foot_z = '0;
    sender_idle = 27;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset links: zero leg, unit upper and lower links, degenerate atan2 arguments
    put_item(0, 0, 0, 0, 0, 0);
    put_item(1, 0, 0, 0, 0, 0);
    put_item(0, 0, 1, 0, 0, 0);
    put_item(-1, 0, 0, 0, 0, 0);
    put_item(0, 0, 0, 0, 0, 1);
    drain();
    set_leg(32767, 32767, 32767, 32767, 32767, 32767);
    put_item(32767, 0, 32767, -32768, 0, -32768);
    put_item(32767, 32767, 0, -32768, -32768, 0);
    put_item(-32768, -32768, -32768, 32767, 32767, 32767);
    put_item(0, 0, 0, 0, 0, 0);
    drain();
    set_leg(-32768, -32768, -32768, 0, 32767, 32767);
    put_item(-32768, 0, -32768, 32767, 0, 32767);
    put_item(0, -100, 0, 32767, 0, 32767);
    put_item(32767, 32767, 32767, -32768, -32768, -32768);
    drain();
    // a zero link can never reach
    set_leg(0, 0, 0, 100, 0, 500);
    put_item(300, 0, 300, 0, 0, 0);
    drain();
    set_reg(qlik_pkg::REG_UPPER_LENGTH, 400);
    set_reg(qlik_pkg::REG_LOWER_LENGTH, 0);
    @(posedge clk);
    put_item(300, 0, 300, 0, 0, 0);
    drain();
    set_leg(0, 0, 0, 1000, 3000, 3000);
    put_item(0, 0, 0, -1000, 0, 0);
    put_item(0, 0, 0, 0, 0, 7000);
    put_item(0, 0, 0, -3000, 500, -3000);
    put_item(0, 0, 0, 6000, 0, 0);
    drain();

    for (int p = 0; p < 4; p++) random_phase(70);
    sender_idle = 81;
    for (int p = 0; p < 4; p++) random_phase(70);
    sender_idle = 0;
    for (int p = 0; p < 4; p++) random_phase(70);

    if (fail_count == 0 && angles_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/qlik_pkg.sv
hw/rtl/qlik_front.sv
hw/rtl/qlik_sqrt.sv
hw/rtl/qlik_atan2.sv
hw/rtl/quadruped_leg_inverse_kinematics.sv
sim/leg_ik_checker.sv
sim/tb_top.sv
